// File: hw/rtl/rcpc_pkg.sv
// ----------------------------------------------------------------------------
// rcpc_pkg: shared types and constants
// Word layouts, configuration register map and reset values for the RC pulse
// capture / ESC drive block.
// ----------------------------------------------------------------------------
package rcpc_pkg;

	localparam int TICK_W           = 32;
	localparam int WIDTH_W          = 16;
	localparam int PULSE_W          = 12;
	localparam int PERIOD_W         = 16;
	localparam int LANES            = 4;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 16;
	localparam int MEASURE_BITS_DEF = 16;

	localparam int THROTTLE_LANE = 2;

	localparam logic [PULSE_W-1:0]  THROTTLE_CAP_RST = 12'd1750;
	localparam logic [PULSE_W-1:0]  PULSE_MIN_RST    = 12'd1100;
	localparam logic [PULSE_W-1:0]  PULSE_MAX_RST    = 12'd1950;
	localparam logic [PULSE_W-1:0]  IDLE_PULSE_RST   = 12'd1000;
	localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RST = 16'd4000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ARMED        = 3'd0,
		REG_THROTTLE_CAP = 3'd1,
		REG_PULSE_MIN    = 3'd2,
		REG_PULSE_MAX    = 3'd3,
		REG_IDLE_PULSE   = 3'd4,
		REG_FRAME_PERIOD = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic roll_pin;
		logic pitch_pin;
		logic throttle_pin;
		logic yaw_pin;
	} in_word_t;

	typedef struct packed {
		logic [LANES-1:0]   esc_drive;
		logic [WIDTH_W-1:0] roll_width;
		logic [WIDTH_W-1:0] pitch_width;
		logic [WIDTH_W-1:0] throttle_width;
		logic [WIDTH_W-1:0] yaw_width;
		logic [PULSE_W-1:0] active_pulse;
	} out_word_t;

	typedef struct packed {
		logic               armed;
		logic [PULSE_W-1:0] throttle_cap;
		logic [PULSE_W-1:0] pulse_min;
		logic [PULSE_W-1:0] pulse_max;
		logic [PULSE_W-1:0] idle_pulse;
	} pulse_cfg_t;

	// frame position of a word travelling to the merge stage
	typedef struct packed {
		logic                frame_start;
		logic [PERIOD_W-1:0] frame_count;
	} frame_info_t;

endpackage

// File: hw/rtl/rc_pulse_capture_esc_drive.sv
// ----------------------------------------------------------------------------
// rc_pulse_capture_esc_drive: RC receiver capture and ESC pulse drive
// Four pin lanes measure receiver high times; a merge stage picks the
// frame pulse and drives the four ESC levels, one result word per tick.
// ----------------------------------------------------------------------------
// Pipeline: lane and stage-1 frame registers, then the merge output register.
// Throughput: one word per cycle unless the skid is full; lanes and frame
// counter update in the accept cycle; pulse choice, drive compare in merge.
// Output has a skid register, so input keeps flowing while one result waits.
// Reset: asynchronous; registers to their reset values, counters and widths 0.
module rc_pulse_capture_esc_drive #(
	parameter int MEASURE_BITS = rcpc_pkg::MEASURE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  rcpc_pkg::in_word_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output rcpc_pkg::out_word_t             out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rcpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcpc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rcpc_pkg::*;

	pulse_cfg_t          cfg_q;
	logic [PERIOD_W-1:0] frame_period_q;
	logic [TICK_W-1:0]   tick_q;
	logic [PERIOD_W-1:0] frame_count_q;
	logic [PERIOD_W-1:0] period;
	logic [PERIOD_W-1:0] count_eff;
	logic [PERIOD_W:0]   count_inc;
	logic [PERIOD_W-1:0] count_next;
	logic                accept;
	logic                valid_s1;
	frame_info_t         frame_s1;
	logic                s1_take;
	logic [LANES-1:0]    pins;
	logic [WIDTH_W-1:0]  widths [LANES];

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.armed        <= 1'b1;
			cfg_q.throttle_cap <= THROTTLE_CAP_RST;
			cfg_q.pulse_min    <= PULSE_MIN_RST;
			cfg_q.pulse_max    <= PULSE_MAX_RST;
			cfg_q.idle_pulse   <= IDLE_PULSE_RST;
			frame_period_q     <= FRAME_PERIOD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ARMED:        cfg_q.armed        <= cfg_data[0];
				REG_THROTTLE_CAP: cfg_q.throttle_cap <= cfg_data[PULSE_W-1:0];
				REG_PULSE_MIN:    cfg_q.pulse_min    <= cfg_data[PULSE_W-1:0];
				REG_PULSE_MAX:    cfg_q.pulse_max    <= cfg_data[PULSE_W-1:0];
				REG_IDLE_PULSE:   cfg_q.idle_pulse   <= cfg_data[PULSE_W-1:0];
				REG_FRAME_PERIOD: frame_period_q     <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// input side
	assign in_ready = !valid_s1 || s1_take;
	assign accept   = in_valid && in_ready;
	assign pins     = {in_data.yaw_pin, in_data.throttle_pin,
		in_data.pitch_pin, in_data.roll_pin};

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		rcpc_lane #(
			.MEASURE_BITS(MEASURE_BITS)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.take  (accept),
			.level (pins[g]),
			.tick  (tick_q),
			.width (widths[g])
		);
	end

	// frame counter; a count at or past the period restarts the frame
	always_comb begin
		period     = (frame_period_q == '0) ? PERIOD_W'(1) : frame_period_q;
		count_eff  = (frame_count_q >= period) ? '0 : frame_count_q;
		count_inc  = {1'b0, count_eff} + 1'b1;
		count_next = (count_inc >= {1'b0, period}) ? '0 : count_inc[PERIOD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q        <= '0;
			frame_count_q <= '0;
			valid_s1      <= 1'b0;
		end else begin
			if (accept) begin
				tick_q        <= tick_q + 1'b1;
				frame_count_q <= count_next;
				valid_s1      <= 1'b1;
			end else if (s1_take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// lane widths are registered in the lanes on the same edge
	always_ff @(posedge clk) begin
		if (accept) begin
			frame_s1.frame_start <= (count_eff == '0);
			frame_s1.frame_count <= count_eff;
		end
	end

	rcpc_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s1_valid (valid_s1),
		.s1_frame (frame_s1),
		.widths   (widths),
		.s1_take  (s1_take),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	a_drive_uniform: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.esc_drive == 4'h0 || out_data.esc_drive == 4'hF))
		else $error("esc drive bits differ");

	a_zero_pulse_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.active_pulse == '0) |-> out_data.esc_drive == 4'h0)
		else $error("drive high with zero pulse");

	a_tick_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(tick_q))
		else $error("tick advanced without accepted word");

endmodule

// File: hw/rtl/rcpc_lane.sv
// ----------------------------------------------------------------------------
// rcpc_lane: one receiver channel
// Edge detect, rise timestamp and saturating high-time measurement for a
// single pin. Four copies run side by side.
// ----------------------------------------------------------------------------
module rcpc_lane #(
	parameter int MEASURE_BITS = rcpc_pkg::MEASURE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic                         level,
	input  logic [rcpc_pkg::TICK_W-1:0]  tick,
	output logic [rcpc_pkg::WIDTH_W-1:0] width
);
	import rcpc_pkg::*;

	localparam int MW = (MEASURE_BITS < WIDTH_W) ? MEASURE_BITS : WIDTH_W;

	logic              prior_q;
	logic [TICK_W-1:0] stamp_q;
	logic [TICK_W-1:0] diff;
	logic [MW-1:0]     width_q;
	logic [MW-1:0]     width_sat;

	// wrapping difference, saturated at all ones of the stored width
	assign diff      = tick - stamp_q;
	assign width_sat = (diff[TICK_W-1:MW] != '0) ? '1 : diff[MW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_q <= 1'b0;
			stamp_q <= '0;
			width_q <= '0;
		end else if (take) begin
			if (level && !prior_q) begin
				stamp_q <= tick;
			end else if (!level && prior_q) begin
				width_q <= width_sat;
			end
			prior_q <= level;
		end
	end

	assign width = WIDTH_W'(width_q);

endmodule

// File: hw/rtl/rcpc_merge.sv
// ----------------------------------------------------------------------------
// rcpc_merge: pulse selection and output buffer
// Combines the lane widths with the frame position, picks the frame pulse
// and holds result words in a two-deep output register with skid.
// ----------------------------------------------------------------------------
module rcpc_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rcpc_pkg::pulse_cfg_t          cfg,
	input  logic                          s1_valid,
	input  rcpc_pkg::frame_info_t         s1_frame,
	input  logic [rcpc_pkg::WIDTH_W-1:0]  widths [rcpc_pkg::LANES],
	output logic                          s1_take,
	output logic                          out_valid,
	input  logic                          out_ready,
	output rcpc_pkg::out_word_t           out_data
);
	import rcpc_pkg::*;

	logic [PULSE_W-1:0] pulse_q;
	logic [PULSE_W-1:0] capped;
	logic [PULSE_W-1:0] raised;
	logic [PULSE_W-1:0] chosen;
	logic [PULSE_W-1:0] pulse_now;
	logic               drive;
	out_word_t          word;
	out_word_t          main_q;
	out_word_t          skid_q;
	logic               main_valid_q;
	logic               skid_valid_q;
	logic               pop;

	// cap, then raise to min, then lower to max; idle pulse when disarmed
	always_comb begin
		capped = (widths[THROTTLE_LANE] > WIDTH_W'(cfg.throttle_cap)) ?
			cfg.throttle_cap : widths[THROTTLE_LANE][PULSE_W-1:0];
		raised = (capped < cfg.pulse_min) ? cfg.pulse_min : capped;
		chosen = (raised > cfg.pulse_max) ? cfg.pulse_max : raised;
		if (!cfg.armed) begin
			chosen = cfg.idle_pulse;
		end
	end

	assign pulse_now = s1_frame.frame_start ? chosen : pulse_q;
	assign drive     = s1_frame.frame_count < PERIOD_W'(pulse_now);

	always_comb begin
		word.esc_drive      = drive ? '1 : '0;
		word.roll_width     = widths[0];
		word.pitch_width    = widths[1];
		word.throttle_width = widths[2];
		word.yaw_width      = widths[3];
		word.active_pulse   = pulse_now;
	end

	assign s1_take = s1_valid && !skid_valid_q;
	assign pop     = main_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q <= '0;
		end else if (s1_take) begin
			pulse_q <= pulse_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else if (!s1_take) begin
					main_valid_q <= 1'b0;
				end
			end else if (s1_take) begin
				if (!main_valid_q) begin
					main_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (s1_take) begin
				main_q <= word;
			end
		end else if (s1_take) begin
			if (!main_valid_q) begin
				main_q <= word;
			end else begin
				skid_q <= word;
			end
		end
	end

	assign out_valid = main_valid_q;
	assign out_data  = main_q;

endmodule

// File: tb/rc_pulse_capture_esc_drive_tb.sv
// ----------------------------------------------------------------------------
// rc_pulse_capture_esc_drive_tb: self-checking bench for RC capture / ESC drive
// Streams receiver pin words through the block under random idling and a long
// output hold-off, predicts every result word per tick and checks each field.
// ----------------------------------------------------------------------------
module rc_pulse_capture_esc_drive_tb;

	import rcpc_pkg::*;

	localparam int unsigned WIDTH_SAT = (MEASURE_BITS_DEF >= 16) ? 32'hFFFF :
		(32'd1 << MEASURE_BITS_DEF) - 1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE0 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE1 = 3'd7;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_SHOWN   = 60;

	// per-tick predictor of widths, frame pulse and ESC level
	class esc_tick_predictor;
		bit                armed;
		bit [PULSE_W-1:0]  throttle_cap;
		bit [PULSE_W-1:0]  pulse_min;
		bit [PULSE_W-1:0]  pulse_max;
		bit [PULSE_W-1:0]  idle_pulse;
		bit [PERIOD_W-1:0] frame_period;
		bit [TICK_W-1:0]   tick_clock;
		bit [LANES-1:0]    prior_level;
		bit [TICK_W-1:0]   rise_stamp[LANES];
		bit [WIDTH_W-1:0]  measured_width[LANES];
		int unsigned       frame_count;
		bit [PULSE_W-1:0]  frame_pulse;
		out_word_t         tick_results[$];
		int                errors;
		int                shown;

		function new();
			armed        = 1'b1;
			throttle_cap = THROTTLE_CAP_RST;
			pulse_min    = PULSE_MIN_RST;
			pulse_max    = PULSE_MAX_RST;
			idle_pulse   = IDLE_PULSE_RST;
			frame_period = FRAME_PERIOD_RST;
			tick_clock   = '0;
			prior_level  = '0;
			frame_count  = 0;
			frame_pulse  = '0;
			errors       = 0;
			shown        = 0;
			for (int i = 0; i < LANES; i++) begin
				rise_stamp[i]     = '0;
				measured_width[i] = '0;
			end
		endfunction

		function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_ARMED:        armed        = val[0];
				REG_THROTTLE_CAP: throttle_cap = val[PULSE_W-1:0];
				REG_PULSE_MIN:    pulse_min    = val[PULSE_W-1:0];
				REG_PULSE_MAX:    pulse_max    = val[PULSE_W-1:0];
				REG_IDLE_PULSE:   idle_pulse   = val[PULSE_W-1:0];
				REG_FRAME_PERIOD: frame_period = val[PERIOD_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_pins(in_word_t w);
			bit [LANES-1:0] lvl;
			int unsigned    span;
			int unsigned    period;
			int unsigned    p;
			out_word_t      want;
			lvl = {w.yaw_pin, w.throttle_pin, w.pitch_pin, w.roll_pin};
			for (int i = 0; i < LANES; i++) begin
				if (lvl[i] && !prior_level[i]) begin
					rise_stamp[i] = tick_clock;
				end else if (!lvl[i] && prior_level[i]) begin
					span = tick_clock - rise_stamp[i];
					measured_width[i] = WIDTH_W'((span > WIDTH_SAT) ? WIDTH_SAT : span);
				end
			end
			prior_level = lvl;

			period = (frame_period == 0) ? 1 : 32'(frame_period);
			if (frame_count >= period)
				frame_count = 0;
			if (frame_count == 0) begin
				if (!armed) begin
					frame_pulse = idle_pulse;
				end else begin
					// cap, then floor, then ceiling: min above max ends at max
					p = 32'(measured_width[THROTTLE_LANE]);
					if (p > throttle_cap)
						p = 32'(throttle_cap);
					if (p < pulse_min)
						p = 32'(pulse_min);
					if (p > pulse_max)
						p = 32'(pulse_max);
					frame_pulse = p[PULSE_W-1:0];
				end
			end

			want.esc_drive      = (frame_count < frame_pulse) ? '1 : '0;
			want.roll_width     = measured_width[0];
			want.pitch_width    = measured_width[1];
			want.throttle_width = measured_width[2];
			want.yaw_width      = measured_width[3];
			want.active_pulse   = frame_pulse;
			tick_results.push_back(want);

			frame_count++;
			if (frame_count >= period)
				frame_count = 0;
			tick_clock++;
		endfunction

		function void compare_field(string what, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				if (shown < MAX_SHOWN) begin
					shown++;
					$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
				end
			end
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			if (tick_results.size() == 0) begin
				errors++;
				if (shown < MAX_SHOWN) begin
					shown++;
					$display("%0t: result word expected none actual %h", $time, got);
				end
				return;
			end
			want = tick_results.pop_front();
			compare_field("esc_drive", 32'(want.esc_drive), 32'(got.esc_drive));
			compare_field("roll_width", 32'(want.roll_width), 32'(got.roll_width));
			compare_field("pitch_width", 32'(want.pitch_width), 32'(got.pitch_width));
			compare_field("throttle_width", 32'(want.throttle_width),
				32'(got.throttle_width));
			compare_field("yaw_width", 32'(want.yaw_width), 32'(got.yaw_width));
			compare_field("active_pulse", 32'(want.active_pulse), 32'(got.active_pulse));
		endfunction

		function int pending();
			return tick_results.size();
		endfunction
	endclass

	bit                     clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	in_word_t               in_data = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_word_t              out_data;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	esc_tick_predictor sb;
	in_word_t          pin_words[$];
	bit                in_fire;
	int                stall_cycles;
	int                tx_idle_pct;
	int                rx_idle_pct;
	bit                hold_req;
	int                hold_left;
	bit                lane_lvl[LANES];
	int                lane_left[LANES];

	rc_pulse_capture_esc_drive u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// sample all three channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			in_fire = in_valid && in_ready;
			if (cfg_valid && cfg_ready)
				sb.apply_reg(cfg_index, cfg_data);
			if (in_fire)
				sb.take_pins(in_data);
			if (out_valid && out_ready)
				sb.check_word(out_data);
			if (in_fire || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	always @(negedge clk) begin : drive_pins
		logic     nxt_valid;
		in_word_t nxt_word;
		nxt_valid = in_valid;
		nxt_word  = in_data;
		if (in_fire)
			nxt_valid = 1'b0;
		if (arst_n && !nxt_valid && pin_words.size() != 0 &&
				$urandom_range(99) >= tx_idle_pct) begin
			nxt_word  = pin_words.pop_front();
			nxt_valid = 1'b1;
		end
		in_valid <= nxt_valid;
		in_data  <= nxt_word;
	end

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("rc_pulse_capture_esc_drive_tb: FAIL");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// junk in the unused upper bits checks the register masking
	task automatic program_frame(input bit arm, input int cap, input int lo, input int hi,
			input int idle, input int period);
		write_reg(REG_ARMED, {15'($urandom), arm});
		write_reg(REG_THROTTLE_CAP, {4'($urandom), cap[11:0]});
		write_reg(REG_PULSE_MIN, {4'($urandom), lo[11:0]});
		write_reg(REG_PULSE_MAX, {4'($urandom), hi[11:0]});
		write_reg(REG_IDLE_PULSE, {4'($urandom), idle[11:0]});
		write_reg(REG_FRAME_PERIOD, period[15:0]);
	endtask

	// nibbles MSB first: roll, pitch, throttle, yaw
	task automatic queue_pins(input bit [63:0] seq, input int n);
		for (int k = n - 1; k >= 0; k--)
			pin_words.push_back(in_word_t'(seq[4*k +: 4]));
	endtask

	task automatic drain();
		while (pin_words.size() != 0 || in_valid || sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// receiver-like pulse trains per lane, with the odd noise word
	function automatic in_word_t next_pins(int hi_max, int lo_max);
		bit [LANES-1:0] p;
		for (int i = 0; i < LANES; i++) begin
			if (lane_left[i] == 0) begin
				lane_lvl[i]  = !lane_lvl[i];
				lane_left[i] = lane_lvl[i] ? $urandom_range(hi_max, 1) :
					$urandom_range(lo_max, 1);
			end
			lane_left[i]--;
			p[i] = lane_lvl[i];
		end
		if ($urandom_range(7) == 0)
			p = LANES'($urandom_range(15));
		return {p[0], p[1], p[2], p[3]};
	endfunction

	initial begin
		int n;
		int hi_max;
		int lo_max;
		sb = new();
		tx_idle_pct = 29;
		rx_idle_pct = 48;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: all-low, all-high and each pin alone
		queue_pins(64'h0FF0_8421_00F, 11);
		drain();

		// ignored indexes, disarmed with zero idle pulse, zero period
		write_reg(CFG_IDX_SPARE0, 16'($urandom));
		write_reg(CFG_IDX_SPARE1, 16'($urandom));
		program_frame(1'b0, 0, 0, 0, 0, 0);
		queue_pins(64'hF0F0, 4);
		drain();

		// wide open clamp, short throttle pulses
		program_frame(1'b1, 4095, 0, 4095, 4095, 3);
		queue_pins(64'h2220_02, 6);
		drain();

		// floor above ceiling
		program_frame(1'b1, 4095, 2000, 5, 0, 2);
		queue_pins(64'h2020, 4);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			tx_idle_pct = (ph < 4) ? 29 : (ph < 8) ? 48 : 0;
			rx_idle_pct = (ph < 4) ? 48 : (ph < 8) ? 29 : 0;
			case (ph)
				3:  program_frame(1'b1, 4095, 4095, 4095, 4095, 65535);
				7:  program_frame(1'b0, 0, 0, 0, 4095, 1);
				11: program_frame(1'b1, 0, 0, 0, 0, 2);
				default: program_frame($urandom_range(3) != 0, $urandom_range(90),
					$urandom_range(70), $urandom_range(90), $urandom_range(70),
					$urandom_range(60, 1));
			endcase
			hi_max = $urandom_range(100, 2);
			lo_max = $urandom_range(40, 1);
			if (ph == 2 || ph == 8)
				hold_req = 1'b1;
			n = $urandom_range(170, 120);
			repeat (n) pin_words.push_back(next_pins(hi_max, lo_max));
			drain();
		end

		// all pins held high for a long pulse
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		program_frame(1'b1, 4095, 0, 4095, 0, 100);
		repeat (150) pin_words.push_back(in_word_t'(4'hF));
		repeat (3) pin_words.push_back(in_word_t'(4'h0));
		drain();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("rc_pulse_capture_esc_drive_tb: PASS");
		else
			$display("rc_pulse_capture_esc_drive_tb: FAIL");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/rcpc_pkg.sv
hw/rtl/rcpc_lane.sv
hw/rtl/rcpc_merge.sv
hw/rtl/rc_pulse_capture_esc_drive.sv
tb/rc_pulse_capture_esc_drive_tb.sv
